[design/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants shared by the first-fit heap allocator modules.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int HEAP_BYTES   = 4194304;
  localparam int ALIGN_BYTES  = 16;
  localparam int HEADER_BYTES = 24;

  localparam logic [0:0] REQ_ALLOC = 1'b0;
  localparam logic [0:0] REQ_FREE  = 1'b1;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_NOFIT   = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_FREED   = 3'd4;

  localparam logic [2:0] MODE_SEARCH = 3'd0;
  localparam logic [2:0] MODE_INSERT = 3'd1;
  localparam logic [2:0] MODE_PULL1  = 3'd2;
  localparam logic [2:0] MODE_PULL2  = 3'd3;
  localparam logic [2:0] MODE_DONE   = 3'd4;

  typedef struct packed {
    logic [0:0]  req_type;
    logic [22:0] req_size;
    logic [21:0] req_addr;
  } req_t;

  typedef struct packed {
    logic [21:0] resp_addr;
    logic [2:0]  resp_status;
  } resp_t;

  typedef struct packed {
    logic        v;
    logic        taken;
    logic [21:0] start;
    logic [22:0] bytes;
  } ent_t;

  typedef struct packed {
    logic        active;
    logic [2:0]  mode;
    logic        op_free;
    logic        room;
    logic [24:0] key;
    ent_t        carry;
    logic [2:0]  status;
    logic [21:0] addr;
    logic        inc;
    logic [1:0]  dec;
  } tok_t;

  typedef struct packed {
    logic        en;
    logic [22:0] val;
  } mrg_t;

endpackage

[design/ffha_cell.sv]
// ----------------------------------------------------------------------------
// ffha_cell
// One descriptor of the block table and its share of the walking request.
// ----------------------------------------------------------------------------
module ffha_cell import ffha_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  ent_t rst_ent,
  input  tok_t tok_i,
  output tok_t tok_o,
  input  ent_t left_i,
  input  ent_t right_i,
  input  ent_t right2_i,
  input  mrg_t mrg_i,
  output mrg_t mrg_o,
  output ent_t ent_o
);

  ent_t ent_r;
  ent_t ent_nxt;

  logic        fit;
  logic        split;
  logic        match;
  logic        lf;
  logic        rf;
  logic [25:0] need_hdr;

  assign fit      = ent_r.v && !ent_r.taken && ({2'b0, ent_r.bytes} >= tok_i.key);
  assign need_hdr = {1'b0, tok_i.key} + 26'(HEADER_BYTES);
  assign split    = ({3'b0, ent_r.bytes} >= need_hdr) && ({2'b0, ent_r.bytes} > tok_i.key)
                    && tok_i.room;
  assign match    = ent_r.v && (({3'b0, ent_r.start} + 25'(HEADER_BYTES)) == tok_i.key);
  assign lf       = left_i.v && !left_i.taken;
  assign rf       = right_i.v && !right_i.taken;

  always_comb begin
    ent_nxt = ent_r;
    tok_o   = tok_i;
    mrg_o   = '0;
    if (mrg_i.en) begin
      ent_nxt.bytes = ent_r.bytes + mrg_i.val;
    end
    if (tok_i.active) begin
      unique case (tok_i.mode)
        MODE_SEARCH: begin
          if (!tok_i.op_free) begin
            if (fit) begin
              ent_nxt.taken = 1'b1;
              tok_o.status  = ST_OK;
              tok_o.addr    = ent_r.start + 22'(HEADER_BYTES);
              tok_o.mode    = MODE_DONE;
              if (split) begin
                ent_nxt.bytes     = tok_i.key[22:0];
                tok_o.mode        = MODE_INSERT;
                tok_o.inc         = 1'b1;
                tok_o.carry.v     = 1'b1;
                tok_o.carry.taken = 1'b0;
                tok_o.carry.start = ent_r.start + tok_i.key[21:0];
                tok_o.carry.bytes = ent_r.bytes - tok_i.key[22:0];
              end
            end
          end else if (match) begin
            tok_o.mode = MODE_DONE;
            if (!ent_r.taken) begin
              tok_o.status = ST_FREED;
            end else begin
              tok_o.status  = ST_OK;
              ent_nxt.taken = 1'b0;
              if (lf && rf) begin
                mrg_o.en   = 1'b1;
                mrg_o.val  = ent_r.bytes + right_i.bytes;
                ent_nxt    = right2_i;
                tok_o.mode = MODE_PULL2;
                tok_o.dec  = 2'd2;
              end else if (lf) begin
                mrg_o.en   = 1'b1;
                mrg_o.val  = ent_r.bytes;
                ent_nxt    = right_i;
                tok_o.mode = MODE_PULL1;
                tok_o.dec  = 2'd1;
              end else if (rf) begin
                ent_nxt.bytes = ent_r.bytes + right_i.bytes;
                tok_o.mode    = MODE_PULL1;
                tok_o.dec     = 2'd1;
              end
            end
          end
        end
        MODE_INSERT: begin
          ent_nxt     = tok_i.carry;
          tok_o.carry = ent_r;
        end
        MODE_PULL1: ent_nxt = right_i;
        MODE_PULL2: ent_nxt = right2_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= rst_ent;
    end else begin
      ent_r <= ent_nxt;
    end
  end

  assign ent_o = ent_r;

endmodule

[design/first_fit_heap_allocator_core.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit heap allocator with splitting and coalescing of free blocks.
//
// The block table lives in a row of MAX_BLOCKS cells, one descriptor each, in
// address order. A request enters the row as a token that moves one cell per
// cycle: it finds the first fitting block (or the block to free), updates it,
// and then carries on as an insert or pull wave that shifts the later
// descriptors by one or two places. The result word then passes from the last
// token register through a pending register to the output register; an
// allocate of zero bytes goes to the pending register without entering the
// row. One request is in flight at a time, and a new word is accepted in the
// cycle after the previous result has moved to the output register.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core import ffha_pkg::*; #(
  parameter int MAX_BLOCKS = 64
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  req_t  in_data,
  output logic  out_valid,
  input  logic  out_stall,
  output resp_t out_data
);

  localparam int CW = $clog2(MAX_BLOCKS + 1);

  ent_t ent   [MAX_BLOCKS];
  mrg_t mrg   [MAX_BLOCKS];
  tok_t tok_o [MAX_BLOCKS];
  tok_t tok_r [MAX_BLOCKS + 1];
  tok_t tok_in;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          pend_v_r, pend_v_nxt;
  resp_t         pend_r, pend_nxt;
  logic          out_v_r, out_v_nxt;
  resp_t         out_r, out_nxt;

  logic        accept;
  logic        zero;
  logic        move;
  logic [23:0] rsize;

  assign accept = in_valid && !in_stall;
  assign zero   = (in_data.req_type == REQ_ALLOC) && (in_data.req_size == '0);
  assign rsize  = ({1'b0, in_data.req_size} + 24'(ALIGN_BYTES - 1)) & ~24'(ALIGN_BYTES - 1);
  assign move   = pend_v_r && (!out_v_r || !out_stall);

  always_comb begin
    tok_in         = '0;
    tok_in.active  = accept && !zero;
    tok_in.mode    = MODE_SEARCH;
    tok_in.op_free = (in_data.req_type == REQ_FREE);
    tok_in.room    = (cnt_r < CW'(MAX_BLOCKS));
    if (in_data.req_type == REQ_FREE) begin
      tok_in.key    = {3'b0, in_data.req_addr};
      tok_in.status = ST_UNKNOWN;
    end else begin
      tok_in.key    = {1'b0, rsize} + 25'(HEADER_BYTES);
      tok_in.status = ST_NOFIT;
    end
  end

  genvar k;
  generate
    for (k = 0; k < MAX_BLOCKS; k++) begin : g_cell
      ent_t rst_ent, left_e, right_e, right2_e;
      mrg_t mrg_in;
      if (k == 0) begin : g_first
        assign rst_ent = '{v: 1'b1, taken: 1'b0, start: '0, bytes: 23'(HEAP_BYTES)};
        assign left_e  = '0;
      end else begin : g_rest
        assign rst_ent = '0;
        assign left_e  = ent[k-1];
      end
      if (k + 1 < MAX_BLOCKS) begin : g_r1
        assign right_e = ent[k+1];
        assign mrg_in  = mrg[k+1];
      end else begin : g_r1_end
        assign right_e = '0;
        assign mrg_in  = '0;
      end
      if (k + 2 < MAX_BLOCKS) begin : g_r2
        assign right2_e = ent[k+2];
      end else begin : g_r2_end
        assign right2_e = '0;
      end
      ffha_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .rst_ent  (rst_ent),
        .tok_i    (tok_r[k]),
        .tok_o    (tok_o[k]),
        .left_i   (left_e),
        .right_i  (right_e),
        .right2_i (right2_e),
        .mrg_i    (mrg_in),
        .mrg_o    (mrg[k]),
        .ent_o    (ent[k])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= MAX_BLOCKS; i++) begin
        tok_r[i] <= '0;
      end
    end else begin
      tok_r[0] <= tok_in;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        tok_r[i+1] <= tok_o[i];
      end
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end
    if (move) begin
      out_v_nxt  = 1'b1;
      out_nxt    = pend_r;
      pend_v_nxt = 1'b0;
      busy_nxt   = 1'b0;
    end
    if (accept) begin
      busy_nxt = 1'b1;
      if (zero) begin
        pend_v_nxt = 1'b1;
        pend_nxt   = '{resp_addr: '0, resp_status: ST_ZERO};
      end
    end
    if (tok_r[MAX_BLOCKS].active) begin
      pend_v_nxt = 1'b1;
      pend_nxt   = '{resp_addr: tok_r[MAX_BLOCKS].addr, resp_status: tok_r[MAX_BLOCKS].status};
      cnt_nxt    = cnt_r + CW'(tok_r[MAX_BLOCKS].inc) - CW'(tok_r[MAX_BLOCKS].dec);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= CW'(1);
      busy_r   <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      busy_r   <= busy_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign in_stall  = busy_r;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

[design/ffha_checker.sv]
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks for the first-fit heap allocator.
// ----------------------------------------------------------------------------
module ffha_checker import ffha_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_valid,
  input logic  in_stall,
  input req_t  in_data,
  input logic  out_valid,
  input logic  out_stall,
  input resp_t out_data
);

  // A result word that is held back keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // Only a successful allocation carries a nonzero address.
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.resp_status != ST_OK) |-> out_data.resp_addr == '0)
    else $error("failed request returned an address");

  // The status is one of the five defined codes.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.resp_status == ST_OK) || (out_data.resp_status == ST_ZERO) ||
                  (out_data.resp_status == ST_NOFIT) || (out_data.resp_status == ST_UNKNOWN) ||
                  (out_data.resp_status == ST_FREED))
    else $error("undefined status code");

  // An accepted request blocks the input until its result is produced.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request accepted while one is in flight");

  // A new result word only appears while a request is in flight.
  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word without a request");

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (.*);
